[rtl/assert_macros.svh]
// Assertion macros for the checker file of the gray dither block.
// Needs clk_i and rst_ni visible in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define FSGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FSGD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/fsgd_pkg.sv]
// Shared types, constants and helpers of the gray error-diffusion dither.
// No dependencies.
`default_nettype none

package fsgd_pkg;

  localparam int PIX_W   = 8;   // gray pixel
  localparam int IDX_W   = 8;   // palette index
  localparam int LVL_W   = 9;   // gray_levels register
  localparam int IW_W    = 11;  // image_width register
  localparam int APB_AW  = 3;   // two registers at 0x0 and 0x4
  localparam int DIV_NW  = 17;  // divider dividend / quotient
  localparam int DIV_DW  = 8;   // divider divisor

  // register select, taken from paddr[2]
  localparam logic REG_LEVELS = 1'b0;
  localparam logic REG_WIDTH  = 1'b1;

  // diffused correction in 1/16 units
  typedef logic signed [15:0] err_t;

  function automatic err_t sat16(input logic signed [17:0] v);
    err_t r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/fsgd_div.sv]
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on fsgd_pkg for operand widths.
`default_nettype none

module fsgd_div import fsgd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_NW-1:0] dividend_i,
  input  wire logic [DIV_DW-1:0] divisor_i,
  output logic                   done_o,
  output logic [DIV_NW-1:0]      quotient_o
);

  localparam int CNT_W = $clog2(DIV_NW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_NW - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_DW-1:0] dsr_q, dsr_d;
  logic [DIV_DW:0]   trial;
  logic              ge;

  assign trial = {rem_q, quo_q[DIV_NW-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_NW-2:0], ge};
      rem_d = ge ? DIV_DW'(trial - {1'b0, dsr_q}) : trial[DIV_DW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[rtl/floyd_steinberg_gray_dither.sv]
// Channel   Dir  Width  Contents
// s_axis    in   8+1    tdata: gray_pixel; tuser: start_of_frame
// m_axis    out  8      tdata: palette_index
// apb       in   32     0x0 gray_levels, 0x4 image_width
//
// A pixel passes through line-store read, correction add, reciprocal
// multiply, quantize and error spread. The last pixel of a row then
// writes the two trailing next-row entries and swaps the line banks.
// After reset and after each gray_levels write the step size and its
// reciprocal are computed by a bit-serial divider, with s_axis_tready
// low. A full output register stalls the error-spread step.
`default_nettype none

module floyd_steinberg_gray_dither import fsgd_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // stream in
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [PIX_W-1:0]  s_axis_tdata,   // [7:0] gray_pixel
  input  wire logic              s_axis_tuser,   // [0] start_of_frame
  // stream out
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [IDX_W-1:0]       m_axis_tdata,   // [7:0] palette_index
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int DEPTH = MAX_WIDTH + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_FIX  = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;
  localparam logic [2:0] ST_FL1  = 3'd5;
  localparam logic [2:0] ST_FL2  = 3'd6;

  localparam logic [1:0] CF_IDLE = 2'd0;
  localparam logic [1:0] CF_GO   = 2'd1;
  localparam logic [1:0] CF_STEP = 2'd2;
  localparam logic [1:0] CF_RCP  = 2'd3;

  // ---------------- registers / config ----------------
  logic [LVL_W-1:0] levels_q, levels_d;
  logic [IW_W-1:0]  width_q, width_d;
  logic [1:0]       cfg_st_q, cfg_st_d;
  logic [7:0]       step_q, step_d;
  logic [16:0]      recip_q, recip_d;
  logic [7:0]       lvl_top;
  logic [WW-1:0]    wid_eff;
  logic             cfg_wr;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_dvd, div_quo;
  logic [DIV_DW-1:0] div_dsr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_LEVELS: prdata = 32'(levels_q);
      REG_WIDTH:  prdata = 32'(width_q);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (levels_q < LVL_W'(2)) begin
      lvl_top = 8'd1;
    end else if (levels_q > LVL_W'(256)) begin
      lvl_top = 8'd255;
    end else begin
      lvl_top = 8'(levels_q - LVL_W'(1));
    end
    if (width_q == '0) begin
      wid_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      wid_eff = WW'(MAX_WIDTH);
    end else begin
      wid_eff = WW'(width_q);
    end
  end

  // step = 255 / (L-1), then recip = 2^16 / step on the same divider
  always_comb begin
    levels_d  = levels_q;
    width_d   = width_q;
    cfg_st_d  = cfg_st_q;
    step_d    = step_q;
    recip_d   = recip_q;
    div_start = 1'b0;
    div_dvd   = DIV_NW'(255);
    div_dsr   = lvl_top;
    unique case (cfg_st_q)
      CF_IDLE: ;
      CF_GO: begin
        div_start = 1'b1;
        cfg_st_d  = CF_STEP;
      end
      CF_STEP: begin
        if (div_done) begin
          step_d    = div_quo[7:0];
          div_start = 1'b1;
          div_dvd   = DIV_NW'(65536);
          div_dsr   = div_quo[7:0];
          cfg_st_d  = CF_RCP;
        end
      end
      CF_RCP: begin
        if (div_done) begin
          recip_d  = div_quo;
          cfg_st_d = CF_IDLE;
        end
      end
      default: cfg_st_d = CF_GO;
    endcase
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_LEVELS: begin
          levels_d = pwdata[LVL_W-1:0];
          cfg_st_d = CF_GO;
        end
        REG_WIDTH: width_d = pwdata[IW_W-1:0];
        default: ;
      endcase
    end
  end

  fsgd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------- pixel path ----------------
  logic [2:0]            st_q, st_d;
  logic [XW-1:0]         col_q, col_d;
  logic [XW-1:0]         x_q, x_d;
  logic [PIX_W-1:0]      pix_q, pix_d;
  logic                  sel_q, sel_d;        // bank holding the current row
  logic [CW-1:0]         cnt0_q, cnt0_d;      // entries filled per bank
  logic [CW-1:0]         cnt1_q, cnt1_d;
  logic                  rd_ok_q, rd_ok_d;
  err_t                  carry_q, carry_d;    // 7/16 share for the right neighbor
  err_t                  pa_q, pa_d;          // partial next-row entry x-1
  err_t                  pb_q, pb_d;          // partial next-row entry x
  logic signed [13:0]    old_q, old_d;
  logic [8:0]            n_q, n_d;
  logic [8:0]            q0_q, q0_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic signed [13:0]    err_q, err_d;
  logic [IDX_W-1:0]      out_q, out_d;
  logic                  out_vld_q, out_vld_d;

  err_t                  mem0 [DEPTH];
  err_t                  mem1 [DEPTH];
  err_t                  rd0_q, rd1_q;
  logic                  in_xfer, sof;
  logic [XW-1:0]         x_rd;
  logic                  we;
  logic [AW-1:0]         waddr;
  err_t                  wdata;
  logic [CW-1:0]         cnt_cur, cnt_nxt;

  // LOAD / MUL / FIX / ERR datapath
  err_t                  stored, cur;
  logic signed [16:0]    t17;
  logic signed [13:0]    old_c;
  logic [7:0]            v;
  logic [25:0]           prod;
  logic [16:0]           qs;
  logic [8:0]            qs9, rem, q, qstep;
  logic                  fix;
  logic [7:0]            pal;
  logic signed [17:0]    e3, e5, e7;
  err_t                  nf;
  logic                  row_end, out_free;

  assign s_axis_tready = (st_q == ST_IDLE) && (cfg_st_q == CF_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign sof           = s_axis_tuser;
  assign x_rd          = sof ? '0 : col_q;
  assign cnt_cur       = sel_q ? cnt1_q : cnt0_q;
  assign cnt_nxt       = sel_q ? cnt0_q : cnt1_q;
  assign waddr         = cnt_nxt[AW-1:0];
  assign out_free      = !out_vld_q || m_axis_tready;
  assign row_end       = (32'(x_q) + 32'd1) >= 32'(wid_eff);

  always_comb begin
    stored = rd_ok_q ? (sel_q ? rd1_q : rd0_q) : '0;
    cur    = sat16(18'(stored) + 18'(carry_q));
    // divide by 16 toward zero
    t17    = 17'(cur) + ((cur < 0) ? 17'sd15 : 17'sd0);
    old_c  = $signed({6'b0, pix_q}) + 14'(t17 >>> 4);
    if (old_c < 0) begin
      v = 8'd0;
    end else if (old_c > 14'sd255) begin
      v = 8'd255;
    end else begin
      v = old_c[7:0];
    end

    prod  = 26'(n_q) * 26'(recip_q);
    // reciprocal quotient is exact or one low
    qs    = 17'(q0_q) * 17'(step_q);
    qs9   = qs[8:0];
    rem   = n_q - qs9;
    fix   = rem >= 9'(step_q);
    q     = q0_q + 9'(fix);
    qstep = qs9 + (fix ? 9'(step_q) : 9'd0);
    if (q >= 9'(lvl_top)) begin
      pal = 8'd255;
    end else begin
      pal = qstep[7:0];
    end

    e3 = 18'(err_q) * 18'sd3;
    e5 = 18'(err_q) * 18'sd5;
    e7 = 18'(err_q) * 18'sd7;
    nf = sat16(18'(pa_q) + e3);
  end

  always_comb begin
    st_d      = st_q;
    col_d     = col_q;
    x_d       = x_q;
    pix_d     = pix_q;
    sel_d     = sel_q;
    cnt0_d    = cnt0_q;
    cnt1_d    = cnt1_q;
    rd_ok_d   = rd_ok_q;
    carry_d   = carry_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    old_d     = old_q;
    n_d       = n_q;
    q0_d      = q0_q;
    idx_d     = idx_q;
    err_d     = err_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    we        = 1'b0;
    wdata     = pa_q;

    unique case (st_q)
      ST_IDLE: begin
        if (in_xfer) begin
          pix_d   = s_axis_tdata;
          x_d     = x_rd;
          rd_ok_d = !sof && (32'(x_rd) < 32'(cnt_cur));
          if (sof) begin
            sel_d   = 1'b0;
            cnt0_d  = '0;
            cnt1_d  = '0;
            carry_d = '0;
            pa_d    = '0;
            pb_d    = '0;
          end
          st_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        old_d = old_c;
        n_d   = 9'(v) + 9'(step_q[7:1]);
        st_d  = ST_MUL;
      end
      ST_MUL: begin
        q0_d = prod[24:16];
        st_d = ST_FIX;
      end
      ST_FIX: begin
        idx_d = (q >= 9'(lvl_top)) ? lvl_top : q[7:0];
        err_d = old_q - $signed({6'b0, pal});
        st_d  = ST_ERR;
      end
      ST_ERR: begin
        if (out_free) begin
          out_d     = idx_q;
          out_vld_d = 1'b1;
          if (x_q != '0) begin
            we    = 1'b1;
            wdata = nf;
          end
          pa_d    = sat16(18'(pb_q) + e5);
          pb_d    = 16'(err_q);
          carry_d = 16'(e7);
          if (row_end) begin
            st_d = ST_FL1;
          end else begin
            col_d = x_q + 1'b1;
            st_d  = ST_IDLE;
          end
        end
      end
      ST_FL1: begin
        we    = 1'b1;
        wdata = pa_q;
        st_d  = ST_FL2;
      end
      ST_FL2: begin
        we      = 1'b1;
        wdata   = pb_q;
        sel_d   = ~sel_q;
        col_d   = '0;
        carry_d = '0;
        pa_d    = '0;
        pb_d    = '0;
        st_d    = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase

    // writes fill the next-row bank in order
    if (we) begin
      if (sel_q) begin
        cnt0_d = cnt0_q + 1'b1;
      end else begin
        cnt1_d = cnt1_q + 1'b1;
      end
    end
    // the old current bank becomes the next-row bank, empty
    if (st_q == ST_FL2) begin
      if (sel_q) begin
        cnt1_d = '0;
      end else begin
        cnt0_d = '0;
      end
    end
  end

  // Both banks are read and the current one is selected; writes go to the other one, so no overlap.
  always_ff @(posedge clk_i) begin
    if (we && sel_q) begin
      mem0[waddr] <= wdata;
    end
    if (we && !sel_q) begin
      mem1[waddr] <= wdata;
    end
    if (in_xfer) begin
      rd0_q <= mem0[x_rd[AW-1:0]];
      rd1_q <= mem1[x_rd[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q  <= LVL_W'(16);
      width_q   <= IW_W'(1024);
      cfg_st_q  <= CF_GO;
      st_q      <= ST_IDLE;
      col_q     <= '0;
      sel_q     <= 1'b0;
      cnt0_q    <= '0;
      cnt1_q    <= '0;
      rd_ok_q   <= 1'b0;
      carry_q   <= '0;
      pa_q      <= '0;
      pb_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      levels_q  <= levels_d;
      width_q   <= width_d;
      cfg_st_q  <= cfg_st_d;
      st_q      <= st_d;
      col_q     <= col_d;
      sel_q     <= sel_d;
      cnt0_q    <= cnt0_d;
      cnt1_q    <= cnt1_d;
      rd_ok_q   <= rd_ok_d;
      carry_q   <= carry_d;
      pa_q      <= pa_d;
      pb_q      <= pb_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    recip_q <= recip_d;
    x_q     <= x_d;
    pix_q   <= pix_d;
    old_q   <= old_d;
    n_q     <= n_d;
    q0_q    <= q0_d;
    idx_q   <= idx_d;
    err_q   <= err_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

[rtl/fsgd_sva.sv]
// Port-level checks for the gray dither top level, bound into it below.
// Depends on fsgd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fsgd_sva import fsgd_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic [PIX_W-1:0]  s_axis_tdata,
  input wire logic              s_axis_tuser,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [IDX_W-1:0]  m_axis_tdata,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [APB_AW-1:0] paddr,
  input wire logic [31:0]       pwdata,
  input wire logic [31:0]       prdata,
  input wire logic              pready
);

  logic in_xfer, lvl_wr;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign lvl_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_LEVELS);

  // one pixel in flight: the input closes right after a transfer
  `FSGD_ASSERT(a_one_in_flight, in_xfer |=> !s_axis_tready, "input taken while busy")

  // a new result only appears after the block was busy computing it
  `FSGD_ASSERT(a_result_from_work, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result without work")

  // a gray_levels write restarts the step computation
  `FSGD_ASSERT(a_levels_recalc, lvl_wr |=> !s_axis_tready, "input open during step recompute")

  // stalled result holds
  `FSGD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed under stall")

endmodule

bind floyd_steinberg_gray_dither fsgd_sva u_fsgd_sva (.*);

`default_nettype wire
